@@ rtl/core/refcounted_page_allocator_defines.svh @@
// Assertion macros shared by the page allocator RTL.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define RPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rpa_pkg.sv @@
// Shared types, codes and defaults for the page allocator.
`default_nettype none
package rpa_pkg;

  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF = 8;

  localparam int FFP_W    = 10;
  localparam int PADDR_W  = 22;
  localparam int RCOUNT_W = 8;

  localparam logic [FFP_W-1:0] FFP_RESET = 10'd64;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INC   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FREE   = 3'd1;
  localparam logic [2:0] ST_FREE_UNREF = 3'd2;
  localparam logic [2:0] ST_TOO_HIGH   = 3'd3;
  localparam logic [2:0] ST_INC_UNREF  = 3'd4;
  localparam logic [2:0] ST_NO_MEM     = 3'd5;
  localparam logic [2:0] ST_OVERFLOW   = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
  } rpa_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [PADDR_W-1:0]  page_address;
    logic [RCOUNT_W-1:0] use_count;
  } rpa_rsp_t;

  // Free stack controls from the sequencer.
  typedef struct packed {
    logic rd;          // read top entry (at transaction accept)
    logic pop;         // commit a pop
    logic push;        // commit a push
    logic take_fresh;  // commit issue of a never-used page
  } rpa_stk_op_t;

endpackage
`default_nettype wire

@@ rtl/core/rpa_refs.sv @@
// Reference count memory: one synchronous read port, one write port.
`default_nettype none
module rpa_refs import rpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [PW-1:0]         rd_page,
  output logic      [COUNT_BITS-1:0] rd_count,
  input  wire logic                  wr_en,
  input  wire logic [PW-1:0]         wr_page,
  input  wire logic [COUNT_BITS-1:0] wr_count
);

  logic [COUNT_BITS-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_page] <= wr_count;
    end
    if (rd_en) begin
      rd_count <= mem[rd_page];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rpa_stack.sv @@
// LIFO free stack memory plus the fresh-page watermark.
`default_nettype none
`include "refcounted_page_allocator_defines.svh"
module rpa_stack import rpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rpa_stk_op_t   op,
  input  wire logic [PW-1:0] push_page,
  output logic      [PW-1:0] top_page,
  output logic               depth_nz,
  output logic      [PW:0]   fresh_top
);

  logic [PW-1:0] mem [NUM_PAGES];
  logic [PW:0]   depth;
  logic          full;
  logic          over_issued;

  assign depth_nz = (depth != '0);
  assign full     = (depth >= (PW+1)'(NUM_PAGES));
  assign over_issued = ((PW+2)'(depth) + (PW+2)'(fresh_top)) > (PW+2)'(NUM_PAGES);

  // top entry sits at depth-1; garbage when empty, never used then
  always_ff @(posedge clk) begin
    if (op.push && !full) begin
      mem[depth[PW-1:0]] <= push_page;
    end
    if (op.rd) begin
      top_page <= mem[PW'(depth - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      fresh_top <= (PW+1)'(NUM_PAGES);
    end else begin
      if (op.pop && depth_nz) begin
        depth <= depth - 1'b1;
      end else if (op.push && !full) begin
        depth <= depth + 1'b1;
      end
      if (op.take_fresh && fresh_top != '0) begin
        fresh_top <= fresh_top - 1'b1;
      end
    end
  end

  // a free page is always an issued page
  `RPA_ASSERT_IMPLY(a_depth_le_issued, 1'b1, !over_issued, "free stack deeper than issued pages")
  `RPA_ASSERT_NEXT(a_fresh_monotonic, 1'b1, fresh_top <= $past(fresh_top), "fresh watermark rose")

endmodule
`default_nettype wire

@@ rtl/core/refcounted_page_allocator.sv @@
// Top level: reference-counted physical page allocator.
// Usage:
//  - req channel (valid/ready) carries one command: allocate, free, increment
//    reference or read count, plus a byte address (ignored by allocate).
//  - rsp channel (valid/ready) returns exactly one status / page address /
//    count per command, in order.
//  - cfg_we/cfg_wdata write first_free_page; write only while idle.
// Timing: a command is accepted in the idle state and its count and stack
//  entries are read from synchronous memory; in the execute state, once the
//  output register is free, the modified count and stack are written back and
//  the response is loaded into the output register, raising rsp_valid. A new
//  command is accepted only after the previous one has been written back, a
//  limit set by the read-modify-write of the count memory.
// Stall: while a response waits in the output register the next command is
//  still accepted and read; its write-back waits until the register frees.
// Reset: the stack is empty and every page is unissued. Counts need no
//  clearing pass: a page below the fresh watermark has never been issued and
//  reads as zero, so the count memory itself is never cleared.
`default_nettype none
`include "refcounted_page_allocator_defines.svh"
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire rpa_req_t         req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rpa_rsp_t              rsp,
  input  wire logic             cfg_we,
  input  wire logic [FFP_W-1:0] cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state;
  logic [FFP_W-1:0] first_free_page;
  logic [1:0]       cmd_q;
  logic [31:0]      addr_q;
  logic             accept;
  logic             commit;
  logic             mem_write;

  // memory interfaces
  rpa_stk_op_t           stk_op;
  logic [PW-1:0]         push_page;
  logic [PW-1:0]         top_page;
  logic                  depth_nz;
  logic [PW:0]           fresh_top;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  ref_wr;
  logic [PW-1:0]         ref_wr_page;
  logic [COUNT_BITS-1:0] ref_wr_count;

  // execute-stage decode
  logic [PW-1:0]         page_q;
  logic                  in_range;
  logic                  aligned;
  logic [COUNT_BITS-1:0] cnt;
  logic [PW-1:0]         alloc_page;
  logic [63:0]           alloc_addr;
  logic [31:0]           out_cnt;
  rpa_rsp_t              rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign mem_write = ref_wr || stk_op.push || stk_op.pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rsp_valid       <= 1'b0;
      first_free_page <= FFP_RESET;
    end else begin
      if (cfg_we) begin
        first_free_page <= cfg_wdata;
      end
      case (state)
        S_IDLE:  if (accept) state <= S_EXEC;
        S_EXEC:  if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.command;
      addr_q <= req.address;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  rpa_stack #(.NUM_PAGES(NUM_PAGES)) u_stack (
    .clk       (clk),
    .rst       (rst),
    .op        (stk_op),
    .push_page (push_page),
    .top_page  (top_page),
    .depth_nz  (depth_nz),
    .fresh_top (fresh_top)
  );

  rpa_refs #(.NUM_PAGES(NUM_PAGES), .COUNT_BITS(COUNT_BITS)) u_refs (
    .clk      (clk),
    .rd_en    (accept),
    .rd_page  (PW'(req.address >> PAGE_BITS)),
    .rd_count (rd_count),
    .wr_en    (ref_wr),
    .wr_page  (ref_wr_page),
    .wr_count (ref_wr_count)
  );

  // Execute: the writes below act only on the commit cycle; the stack read is issued at accept.
  always_comb begin
    page_q   = PW'(addr_q >> PAGE_BITS);
    in_range = (33'(addr_q >> PAGE_BITS) < 33'(NUM_PAGES));
    aligned  = (addr_q[PAGE_BITS-1:0] == '0);
    // pages under the watermark were never issued: count is zero
    cnt      = ((PW+1)'(page_q) >= fresh_top) ? rd_count : '0;

    alloc_page   = top_page;
    alloc_addr   = '0;
    out_cnt      = '0;
    stk_op       = '0;
    stk_op.rd    = accept;
    push_page    = page_q;
    ref_wr       = 1'b0;
    ref_wr_page  = page_q;
    ref_wr_count = cnt;
    rsp_next     = '0;
    rsp_next.status = ST_OK;

    case (cmd_q)
      CMD_ALLOC: begin
        if (depth_nz) begin
          alloc_page = top_page;
          stk_op.pop = commit;
        end else if (32'(fresh_top) > 32'(first_free_page)) begin
          alloc_page        = PW'(fresh_top - 1'b1);
          stk_op.take_fresh = commit;
        end else begin
          rsp_next.status = ST_NO_MEM;
        end
        if (rsp_next.status == ST_OK) begin
          ref_wr       = commit;
          ref_wr_page  = alloc_page;
          ref_wr_count = COUNT_BITS'(1);
          alloc_addr   = 64'(alloc_page) << PAGE_BITS;
          out_cnt      = 32'd1;
        end
      end
      CMD_FREE: begin
        if (!in_range || !aligned || 32'(page_q) < 32'(first_free_page)) begin
          rsp_next.status = ST_BAD_FREE;
        end else if (cnt == '0) begin
          rsp_next.status = ST_FREE_UNREF;
        end else begin
          ref_wr       = commit;
          ref_wr_count = cnt - 1'b1;
          stk_op.push  = commit && (ref_wr_count == '0);
          out_cnt      = 32'(ref_wr_count);
        end
      end
      CMD_INC: begin
        if (!in_range) begin
          rsp_next.status = ST_TOO_HIGH;
        end else if (cnt == '0) begin
          rsp_next.status = ST_INC_UNREF;
        end else if (&cnt) begin
          rsp_next.status = ST_OVERFLOW;
        end else begin
          ref_wr       = commit;
          ref_wr_count = cnt + 1'b1;
          out_cnt      = 32'(ref_wr_count);
        end
      end
      CMD_READ: begin
        if (in_range) begin
          out_cnt = 32'(cnt);
        end
      end
      default: ;
    endcase

    rsp_next.page_address = alloc_addr[PADDR_W-1:0];
    rsp_next.use_count    = out_cnt[RCOUNT_W-1:0];
  end

  // every write-back leaves a response behind it
  `RPA_ASSERT_NEXT(a_commit_rsp, commit, rsp_valid, "write-back without response")
  // no write-back may happen outside the execute cycle
  `RPA_ASSERT_IMPLY(a_write_in_exec, mem_write, commit, "memory write outside commit")

endmodule
`default_nettype wire

@@ tb/refcounted_page_allocator_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for refcounted_page_allocator: directed table, then random traffic.
module refcounted_page_allocator_test;
  import rpa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES_DEF);
  localparam logic [32:0] MEM_TOP = 33'(NUM_PAGES_DEF) << PAGE_BITS_DEF;
  localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;

  localparam int IDLE_PCT        = 36;   // chance of a bubble per cycle, each side
  localparam int HOLD_OFF_CYCLES = 80;   // long receiver stall, fills the pipe
  localparam int DRAIN_PAUSE     = 4;    // a little margin after the drain before a cfg write
  localparam int QUIET_LIMIT     = 2000; // cycles with no transaction on either side

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  rpa_req_t              req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rpa_rsp_t              rsp;
  logic                  cfg_we = 1'b0;
  logic [FFP_W-1:0]      cfg_wdata = '0;

  refcounted_page_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator shadow state. Updated at the edge where a command transaction is
  // accepted, so it always reflects every command the block has taken so far.
  // ---------------------------------------------------------------------------
  logic [FFP_W-1:0]          floor_page = FFP_RESET;
  logic [PW-1:0]             recycled_pages [NUM_PAGES_DEF];
  int                        recycled_depth = 0;
  int                        fresh_mark = NUM_PAGES_DEF;
  logic [COUNT_BITS_DEF-1:0] page_count [NUM_PAGES_DEF];
  int unsigned               handed_out [$];   // every page ever allocated
  int                        last_alloc_page;

  rpa_rsp_t awaited_rsp [$];

  // run bookkeeping
  int  mismatches;
  int  sent_items;
  int  rsp_total;
  int  status_seen [7];
  int  quiet_cycles;
  bit  sender_idle = 1'b1;
  bit  steady_sink = 1'b0;
  bit  hold_off_req = 1'b0;

  // Next response of the allocator for one command; advances the shadow state.
  function automatic rpa_rsp_t predict_page_response(logic [1:0] cmd, logic [31:0] addr);
    rpa_rsp_t r;
    int       pg;
    r  = '0;
    pg = -1;
    if (cmd == CMD_ALLOC) begin
      // recycled pages first (LIFO), then the never-issued range top down
      if (recycled_depth > 0) begin
        recycled_depth--;
        pg = recycled_pages[recycled_depth];
      end else if (fresh_mark > floor_page) begin
        fresh_mark--;
        pg = fresh_mark;
      end
      if (pg < 0) begin
        r.status = ST_NO_MEM;
      end else begin
        page_count[pg] = 1;
        handed_out.push_back(pg);
        last_alloc_page = pg;
        r.page_address  = PADDR_W'(pg << PAGE_BITS_DEF);
        r.use_count     = 1;
      end
      return r;
    end
    // beyond physical memory: free and increment flag it, read returns zero
    if ({1'b0, addr} >= MEM_TOP) begin
      if (cmd == CMD_FREE) r.status = ST_BAD_FREE;
      else if (cmd == CMD_INC) r.status = ST_TOO_HIGH;
      return r;
    end
    pg = int'(addr >> PAGE_BITS_DEF);
    if (cmd == CMD_FREE) begin
      if (addr[PAGE_BITS_DEF-1:0] != 0 || pg < floor_page) begin
        r.status = ST_BAD_FREE;
      end else if (page_count[pg] == 0) begin
        r.status = ST_FREE_UNREF;
      end else begin
        page_count[pg]--;
        // last reference gone: page goes back on the stack
        if (page_count[pg] == 0 && recycled_depth < NUM_PAGES_DEF) begin
          recycled_pages[recycled_depth] = PW'(pg);
          recycled_depth++;
        end
        r.use_count = RCOUNT_W'(page_count[pg]);
      end
    end else if (cmd == CMD_INC) begin
      // no alignment check on increment
      if (page_count[pg] == 0) begin
        r.status = ST_INC_UNREF;
      end else if (page_count[pg] >= COUNT_MAX) begin
        r.status = ST_OVERFLOW;
      end else begin
        page_count[pg]++;
        r.use_count = RCOUNT_W'(page_count[pg]);
      end
    end else begin
      r.use_count = RCOUNT_W'(page_count[pg]);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one command and hold it until accepted. A typed row supplies its own
  // expected response; the shadow state is advanced either way.
  task automatic issue_command(logic [1:0] cmd, logic [31:0] addr, bit typed,
                               rpa_rsp_t typed_rsp);
    rpa_rsp_t predicted;
    if (sender_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= '{command: cmd, address: addr};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = predict_page_response(cmd, addr);
    awaited_rsp.push_back(typed ? typed_rsp : predicted);
    sent_items++;
  endtask

  // Random command biased toward pages that have been allocated, so frees and
  // increments mostly hit real references; the rest is unaligned, out-of-range or noise.
  task automatic issue_random(int alloc_pct);
    logic [1:0]  cmd;
    logic [31:0] addr;
    int          pick;
    logic [PW-1:0] pg;
    pick = $urandom_range(99);
    if (pick < alloc_pct) cmd = CMD_ALLOC;
    else if (pick < alloc_pct + (100 - alloc_pct) * 2 / 5) cmd = CMD_FREE;
    else if (pick < alloc_pct + (100 - alloc_pct) * 7 / 10) cmd = CMD_INC;
    else cmd = CMD_READ;
    if (handed_out.size() != 0) pg = PW'(handed_out[$urandom_range(handed_out.size() - 1)]);
    else pg = PW'($urandom);
    pick = $urandom_range(99);
    if (pick < 65) addr = 32'(pg) << PAGE_BITS_DEF;
    else if (pick < 75) addr = (32'(pg) << PAGE_BITS_DEF) | 32'($urandom_range(4095));
    else if (pick < 85) addr = $urandom;
    else addr = 32'($urandom_range(MEM_TOP - 1));
    issue_command(cmd, addr, 1'b0, '0);
  endtask

  // Drop valid and wait until every outstanding response is back.
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // first_free_page is only written with the block idle.
  task automatic write_floor(logic [FFP_W-1:0] value);
    drain_responses();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    floor_page = value;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: command, address, and where obvious the expected response.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    bit          typed;
    rpa_rsp_t    want;
  } dir_row_t;

  dir_row_t directed_rows [$];

  function automatic void add_row(logic [1:0] cmd, logic [31:0] addr, bit typed,
                                  logic [2:0] st, logic [PADDR_W-1:0] pa,
                                  logic [RCOUNT_W-1:0] cnt);
    dir_row_t r;
    r.cmd   = cmd;
    r.addr  = addr;
    r.typed = typed;
    r.want  = '{status: st, page_address: pa, use_count: cnt};
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random backpressure, long no-stall stretches, and one
  // long hold-off on request so the block backs up into its command port.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ready <= steady_sink || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Scoreboard: each response transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected response: status %0d page_address 0x%0h use_count %0d",
               rsp.status, rsp.page_address, rsp.use_count);
        mismatches++;
      end else begin
        rpa_rsp_t want;
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.page_address !== want.page_address) begin
          $error("page_address: expected 0x%0h, got 0x%0h", want.page_address,
                 rsp.page_address);
          mismatches++;
        end
        if (rsp.use_count !== want.use_count) begin
          $error("use_count: expected %0d, got %0d", want.use_count, rsp.use_count);
          mismatches++;
        end
      end
      if (rsp.status <= ST_OVERFLOW) status_seen[rsp.status]++;
      rsp_total++;
    end
  end

  // Watchdog: too long without any transaction means the block hung.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pg;
    for (int p = 0; p < NUM_PAGES_DEF; p++) page_count[p] = '0;

    // Fresh after reset, floor 64: reads of nothing, the range, alignment, floor and
    // unreferenced error paths, and the first pages coming off the top of memory.
    add_row(CMD_READ,  32'h0000_0000, 1'b1, ST_OK,         '0, 8'd0);
    add_row(CMD_READ,  32'hFFFF_FFFF, 1'b1, ST_OK,         '0, 8'd0);
    add_row(CMD_INC,   32'hFFFF_FFFF, 1'b1, ST_TOO_HIGH,   '0, 8'd0);
    add_row(CMD_FREE,  32'hFFFF_FFFF, 1'b1, ST_BAD_FREE,   '0, 8'd0);
    add_row(CMD_FREE,  32'h0040_0000, 1'b1, ST_BAD_FREE,   '0, 8'd0);  // first byte past memory
    add_row(CMD_INC,   32'h0030_0000, 1'b1, ST_INC_UNREF,  '0, 8'd0);
    add_row(CMD_FREE,  32'h003F_F000, 1'b1, ST_FREE_UNREF, '0, 8'd0);
    add_row(CMD_FREE,  32'h0003_F000, 1'b1, ST_BAD_FREE,   '0, 8'd0);  // just under the floor
    add_row(CMD_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h3F_F000, 8'd1);
    add_row(CMD_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h3F_E000, 8'd1);
    add_row(CMD_FREE,  32'h003F_F001, 1'b1, ST_BAD_FREE,   '0, 8'd0);  // unaligned free
    add_row(CMD_INC,   32'h003F_F123, 1'b0, ST_OK, '0, '0);            // unaligned inc is fine
    add_row(CMD_READ,  32'h003F_FFFF, 1'b0, ST_OK, '0, '0);
    add_row(CMD_FREE,  32'h003F_F000, 1'b0, ST_OK, '0, '0);
    add_row(CMD_FREE,  32'h003F_F000, 1'b0, ST_OK, '0, '0);            // count hits zero, pushed
    add_row(CMD_FREE,  32'h003F_F000, 1'b1, ST_FREE_UNREF, '0, 8'd0);
    add_row(CMD_ALLOC, 32'h0000_0000, 1'b0, ST_OK, '0, '0);            // pops the recycled page
    add_row(CMD_ALLOC, 32'h0000_0000, 1'b0, ST_OK, '0, '0);            // back to fresh pages
    add_row(CMD_READ,  32'h003F_D000, 1'b0, ST_OK, '0, '0);
    add_row(CMD_ALLOC, 32'hFFFF_FFFF, 1'b0, ST_OK, '0, '0);            // address ignored
    add_row(CMD_INC,   32'h003F_C000, 1'b0, ST_OK, '0, '0);
    add_row(CMD_READ,  32'h003F_FFFF, 1'b0, ST_OK, '0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_command(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].typed,
                    directed_rows[i].want);

    // Floor 0: whole memory allocatable. Saturate one page's count with a
    // back-to-back burst (no bubbles on either side), then mixed traffic.
    write_floor('0);
    steady_sink = 1'b1;
    sender_idle = 1'b0;
    issue_command(CMD_ALLOC, 32'd0, 1'b0, '0);
    pg = last_alloc_page;
    repeat (COUNT_MAX + 1) issue_command(CMD_INC, 32'(pg) << PAGE_BITS_DEF, 1'b0, '0);
    issue_command(CMD_READ, 32'(pg) << PAGE_BITS_DEF, 1'b0, '0);
    repeat (2) issue_command(CMD_FREE, 32'(pg) << PAGE_BITS_DEF, 1'b0, '0);
    steady_sink = 1'b0;
    sender_idle = 1'b1;
    repeat (300) issue_random(40);

    // Back the block up: receiver stalls while commands keep coming.
    sender_idle  = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) issue_random(40);
    sender_idle = 1'b1;
    drain_responses();

    // Floor at the very top: only recycled pages, mostly out of memory.
    write_floor('1);
    repeat (150) issue_random(55);

    // Floor just under the current fresh mark region.
    write_floor(10'd1000);
    repeat (250) issue_random(35);

    // Low random floor: fresh pages available again.
    write_floor(FFP_W'($urandom_range(1, 300)));
    repeat (530) issue_random(45);

    drain_responses();

    $display("ran %0d commands over five floor settings, %0d responses checked",
             sent_items, rsp_total);
    $display("statuses ok %0d, bad %0d, unref %0d, high %0d, inc %0d, oom %0d, ovf %0d",
             status_seen[ST_OK], status_seen[ST_BAD_FREE], status_seen[ST_FREE_UNREF],
             status_seen[ST_TOO_HIGH], status_seen[ST_INC_UNREF], status_seen[ST_NO_MEM],
             status_seen[ST_OVERFLOW]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rpa_pkg.sv
rtl/core/rpa_refs.sv
rtl/core/rpa_stack.sv
rtl/core/refcounted_page_allocator.sv
tb/refcounted_page_allocator_test.sv
